// ===== sv/bls_pkg.sv =====
`default_nettype none

package bls_pkg;

  // Grid size: coordinates run from 0 to 2**COORD_BITS - 1.
  localparam int unsigned COORD_BITS = 6;
  // The error term spans -(dx+dy) .. dx+dy, so two bits above a coordinate.
  localparam int unsigned ERR_BITS = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  // One line command as it arrives at the input.
  typedef struct packed {
    coord_t x_start;
    coord_t y_start;
    coord_t x_end;
    coord_t y_end;
  } line_cmd_t;

  // One emitted pixel.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } pixel_t;

  // Classified command handed from the front end to the stepper.
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t goal_x;
    coord_t goal_y;
    coord_t delta_x;
    coord_t delta_y;
    logic   step_x_negative;
    logic   step_y_negative;
    err_t   error_term;
  } step_cmd_t;

endpackage

`default_nettype wire

// ===== sv/bls_front.sv =====
`default_nettype none

module bls_front (
  input  bls_pkg::line_cmd_t line_i,
  input  logic               push,
  input  logic               fifo_full_i,
  output logic               wr_en_o,
  output bls_pkg::step_cmd_t cmd_o
);
  import bls_pkg::*;

  logic   x_fwd;
  logic   y_fwd;
  coord_t dx;
  coord_t dy;
  err_t   dx_ext;
  err_t   dy_half;

  // A transaction is taken whenever the command queue has room.
  assign wr_en_o = push && !fifo_full_i;

  // Absolute extents and step directions of the line.
  assign x_fwd = line_i.x_start < line_i.x_end;
  assign y_fwd = line_i.y_start < line_i.y_end;
  assign dx    = x_fwd ? (line_i.x_end - line_i.x_start) : (line_i.x_start - line_i.x_end);
  assign dy    = y_fwd ? (line_i.y_end - line_i.y_start) : (line_i.y_start - line_i.y_end);

  // Initial error: dx/2 for x-major lines, otherwise -(dy/2).
  assign dx_ext  = err_t'({2'b00, dx >> 1});
  assign dy_half = err_t'({2'b00, dy >> 1});

  always_comb begin
    cmd_o.cur_x           = line_i.x_start;
    cmd_o.cur_y           = line_i.y_start;
    cmd_o.goal_x          = line_i.x_end;
    cmd_o.goal_y          = line_i.y_end;
    cmd_o.delta_x         = dx;
    cmd_o.delta_y         = dy;
    cmd_o.step_x_negative = !x_fwd;
    cmd_o.step_y_negative = !y_fwd;
    cmd_o.error_term      = (dx > dy) ? dx_ext : -dy_half;
  end

endmodule

`default_nettype wire

// ===== sv/bls_cmd_fifo.sv =====
`default_nettype none

module bls_cmd_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  bls_pkg::step_cmd_t wr_data_i,
  input  logic               rd_en_i,
  output bls_pkg::step_cmd_t rd_data_o,
  output logic               full_o,
  output logic               empty_o
);
  import bls_pkg::*;

  localparam int unsigned PtrBits = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(DEPTH + 1);

  step_cmd_t          mem_q [DEPTH];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;

  assign full_o    = count_q == CntBits'(DEPTH);
  assign empty_o   = count_q == '0;
  assign rd_data_o = mem_q[rd_ptr_q];

  // Pointer and fill-count update with wrap at the queue depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (wr_en_i) begin
      wr_ptr_d = (wr_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en_i) begin
      rd_ptr_d = (rd_ptr_q == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en_i && !rd_en_i) begin
      count_d = count_q + 1'b1;
    end else if (!wr_en_i && rd_en_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Queue storage holds payload only.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bls_stepper.sv =====
`default_nettype none

module bls_stepper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bls_pkg::step_cmd_t cmd_i,
  input  logic               cmd_avail_i,
  output logic               cmd_take_o,
  output logic               empty,
  input  logic               pop,
  output bls_pkg::pixel_t    pixel_o
);
  import bls_pkg::*;

  logic      busy_q, busy_d;
  step_cmd_t st_q, st_d;
  logic      out_valid_q, out_valid_d;
  pixel_t    out_q, out_d;
  logic      advance;
  logic      done;
  logic      x_step;
  logic      y_step;
  err_t      dx_ext;
  err_t      dy_ext;

  assign empty   = !out_valid_q;
  assign pixel_o = out_q;

  // A pixel is produced when the output register is free or being drained.
  assign advance    = busy_q && (!out_valid_q || pop);
  assign done       = (st_q.cur_x == st_q.goal_x) && (st_q.cur_y == st_q.goal_y);
  assign cmd_take_o = cmd_avail_i && (!busy_q || (advance && done));

  // Bresenham step decisions, taken on the error before the step.
  assign dx_ext = err_t'({2'b00, st_q.delta_x});
  assign dy_ext = err_t'({2'b00, st_q.delta_y});
  assign x_step = st_q.error_term > -dx_ext;
  assign y_step = st_q.error_term < dy_ext;

  always_comb begin
    busy_d      = busy_q;
    st_d        = st_q;
    out_valid_d = out_valid_q && !pop;
    out_d       = out_q;
    if (advance) begin
      out_valid_d      = 1'b1;
      out_d.pixel_x    = st_q.cur_x;
      out_d.pixel_y    = st_q.cur_y;
      out_d.last_pixel = done;
      if (done) begin
        busy_d = 1'b0;
      end else begin
        st_d.error_term = st_q.error_term - (x_step ? dy_ext : '0) + (y_step ? dx_ext : '0);
        if (x_step) begin
          st_d.cur_x = st_q.step_x_negative ? st_q.cur_x - 1'b1 : st_q.cur_x + 1'b1;
        end
        if (y_step) begin
          st_d.cur_y = st_q.step_y_negative ? st_q.cur_y - 1'b1 : st_q.cur_y + 1'b1;
        end
      end
    end
    // A new command loads as soon as the previous one emits its end pixel.
    if (cmd_take_o) begin
      busy_d = 1'b1;
      st_d   = cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q  <= st_d;
    out_q <= out_d;
  end

endmodule

`default_nettype wire

// ===== sv/bresenham_line_stepper.sv =====
`default_nettype none
// Path: a line command passes through the command queue and the stepper's state register,
// and each pixel of the line then lands in the result register.
// Throughput: one pixel per cycle while pop keeps the result register drained; a line
// gives max(dx,dy)+1 pixels, at most 64, and the next queued line follows with no gap.
// Reset: asynchronous, active low; it empties the command queue and the result register.
module bresenham_line_stepper #(
  parameter int unsigned CMD_DEPTH = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bls_pkg::line_cmd_t  line_i,
  input  logic                push,
  output logic                full,
  output bls_pkg::pixel_t     pixel_o,
  output logic                empty,
  input  logic                pop
);
  import bls_pkg::*;

  step_cmd_t front_cmd;
  step_cmd_t queued_cmd;
  logic      wr_en;
  logic      rd_en;
  logic      q_empty;

  // Front end: takes a transaction and classifies the line.
  bls_front u_front (
    .line_i      (line_i),
    .push        (push),
    .fifo_full_i (full),
    .wr_en_o     (wr_en),
    .cmd_o       (front_cmd)
  );

  // Short queue decoupling the front end from the stepper.
  bls_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (front_cmd),
    .rd_en_i   (rd_en),
    .rd_data_o (queued_cmd),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  // Back end: walks the line one pixel per cycle while the result register is drained.
  bls_stepper u_stepper (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queued_cmd),
    .cmd_avail_i (!q_empty),
    .cmd_take_o  (rd_en),
    .empty       (empty),
    .pop         (pop),
    .pixel_o     (pixel_o)
  );

endmodule

`default_nettype wire

// ===== sv/bls_checker.sv =====
`default_nettype none

module bls_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input bls_pkg::pixel_t    pixel_o,
  input logic               empty,
  input logic               pop
);
  import bls_pkg::*;

  logic                  in_txn;
  logic                  out_txn;
  logic [7:0]            pend_q;
  logic                  prev_valid_q;
  logic                  prev_last_q;
  coord_t                prev_x_q;
  coord_t                prev_y_q;
  logic [COORD_BITS:0]   ddx;
  logic [COORD_BITS:0]   ddy;
  logic                  near_x;
  logic                  near_y;
  logic                  moved;

  assign in_txn  = push && !full;
  assign out_txn = pop && !empty;

  // Count lines accepted but not yet finished by an end-pixel transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q       <= '0;
      prev_valid_q <= 1'b0;
      prev_last_q  <= 1'b0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
    end else begin
      pend_q <= pend_q + 8'(in_txn) - 8'(out_txn && pixel_o.last_pixel);
      if (out_txn) begin
        prev_valid_q <= 1'b1;
        prev_last_q  <= pixel_o.last_pixel;
        prev_x_q     <= pixel_o.pixel_x;
        prev_y_q     <= pixel_o.pixel_y;
      end
    end
  end

  // Distance from the previously delivered pixel.
  assign ddx    = {1'b0, pixel_o.pixel_x} - {1'b0, prev_x_q};
  assign ddy    = {1'b0, pixel_o.pixel_y} - {1'b0, prev_y_q};
  assign near_x = (ddx == '0) || (ddx == (COORD_BITS+1)'(1)) || (ddx == '1);
  assign near_y = (ddy == '0) || (ddy == (COORD_BITS+1)'(1)) || (ddy == '1);
  assign moved  = (ddx != '0) || (ddy != '0);

  // Reset leaves no result waiting and room for a command.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("result or full flag shown during reset");

  // A waiting result stays put until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_o)))
    else $error("waiting result changed before it was taken");

  // No pixel appears unless some accepted line is still unfinished.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q == '0) |-> empty)
    else $error("pixel shown with no line outstanding");

  // Within a line, consecutive pixels are 8-connected neighbors.
  a_connected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_txn && prev_valid_q && !prev_last_q) |-> (near_x && near_y && moved))
    else $error("consecutive line pixels are not neighbors");

endmodule

bind bresenham_line_stepper bls_checker u_bls_checker (.*);

`default_nettype wire

// ===== dv/bresenham_line_stepper_tb.sv =====
`timescale 1ns / 1ps

module bresenham_line_stepper_tb;
  import bls_pkg::*;

  localparam int unsigned NUM_RANDOM = 186;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  line_cmd_t line_i;
  logic      push;
  logic      full;
  pixel_t    pixel_o;
  logic      empty;
  logic      pop;

  // Line commands still to be sent, and the predicted pixels of the commands already accepted.
  line_cmd_t   line_q[$];
  pixel_t      expected_pixels[$];
  int unsigned total_lines;
  int unsigned lines_sent;
  int unsigned fail_cnt;
  int unsigned stall_cycles;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  bresenham_line_stepper i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .line_i (line_i),
    .push   (push),
    .full   (full),
    .pixel_o(pixel_o),
    .empty  (empty),
    .pop    (pop)
  );

  always #5 clk_i = ~clk_i;

  // Walk the line with the all-octant error stepping and queue every pixel it visits.
  function automatic void trace_line(input line_cmd_t cmd);
    int     px;
    int     py;
    int     ex;
    int     ey;
    int     dx;
    int     dy;
    int     sx;
    int     sy;
    int     err;
    int     e2;
    bit     done;
    pixel_t pix;
    px = cmd.x_start;
    py = cmd.y_start;
    ex = cmd.x_end;
    ey = cmd.y_end;
    dx = (ex > px) ? ex - px : px - ex;
    dy = (ey > py) ? ey - py : py - ey;
    sx = (px < ex) ? 1 : -1;
    sy = (py < ey) ? 1 : -1;
    err = ((dx > dy) ? dx : -dy) / 2;
    done = 1'b0;
    while (!done) begin
      done = (px == ex) && (py == ey);
      pix.pixel_x = coord_t'(px);
      pix.pixel_y = coord_t'(py);
      pix.last_pixel = done;
      expected_pixels.push_back(pix);
      if (!done) begin
        e2 = err;
        if (e2 > -dx) begin
          err -= dy;
          px += sx;
        end
        if (e2 < dy) begin
          err += dx;
          py += sy;
        end
      end
    end
  endfunction

  function automatic void queue_line(input int xs, input int ys, input int xe, input int ye);
    line_cmd_t cmd;
    cmd.x_start = coord_t'(xs);
    cmd.y_start = coord_t'(ys);
    cmd.x_end = coord_t'(xe);
    cmd.y_end = coord_t'(ye);
    line_q.push_back(cmd);
  endfunction

  function automatic int near_coord(input int base);
    int c;
    c = base + $urandom_range(10) - 5;
    if (c < 0) c = 0;
    if (c > 63) c = 63;
    return c;
  endfunction

  // Idle rates follow the progress of the command stream: receiver idles more first, then
  // sender, then neither side idles.
  always_comb begin
    if (lines_sent < total_lines / 3) begin
      send_idle_pct = 21;
      recv_idle_pct = 58;
    end else if (lines_sent < (2 * total_lines) / 3) begin
      send_idle_pct = 58;
      recv_idle_pct = 21;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  end

  // Driver: offers the oldest pending command and randomly withholds pop.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
      pop <= 1'b0;
    end else begin
      if (line_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        line_i <= line_q[0];
        push <= 1'b1;
      end else begin
        push <= 1'b0;
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each pixel transaction against the oldest prediction and predicts
  // the pixels of each accepted command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected pixel: x %0d y %0d last %0b",
                 pixel_o.pixel_x, pixel_o.pixel_y, pixel_o.last_pixel);
          fail_cnt++;
        end else begin
          if (pixel_o.pixel_x !== expected_pixels[0].pixel_x) begin
            $error("pixel_x: expected %0d, actual %0d",
                   expected_pixels[0].pixel_x, pixel_o.pixel_x);
            fail_cnt++;
          end
          if (pixel_o.pixel_y !== expected_pixels[0].pixel_y) begin
            $error("pixel_y: expected %0d, actual %0d",
                   expected_pixels[0].pixel_y, pixel_o.pixel_y);
            fail_cnt++;
          end
          if (pixel_o.last_pixel !== expected_pixels[0].last_pixel) begin
            $error("last_pixel: expected %0b, actual %0b",
                   expected_pixels[0].last_pixel, pixel_o.last_pixel);
            fail_cnt++;
          end
          void'(expected_pixels.pop_front());
        end
      end
      if (push && !full) begin
        trace_line(line_q.pop_front());
        lines_sent++;
      end
      // Watchdog on cycles in which no transaction happens on either side.
      if ((pop && !empty) || (push && !full)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int sel;
    int xs;
    int ys;
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    line_i = '0;
    fail_cnt = 0;
    lines_sent = 0;
    stall_cycles = 0;

    // Directed lines: zero length at both corners, full diagonals, axis-aligned lines
    // (equal coordinates on one axis) in both directions, and one line per octant.
    queue_line(0, 0, 0, 0);
    queue_line(63, 63, 63, 63);
    queue_line(0, 0, 63, 63);
    queue_line(63, 63, 0, 0);
    queue_line(0, 63, 63, 0);
    queue_line(63, 0, 0, 63);
    queue_line(0, 5, 63, 5);
    queue_line(63, 5, 0, 5);
    queue_line(5, 0, 5, 63);
    queue_line(5, 63, 5, 0);
    queue_line(10, 10, 40, 20);
    queue_line(10, 10, 20, 40);
    queue_line(40, 20, 10, 10);
    queue_line(20, 40, 10, 10);
    queue_line(10, 40, 40, 30);
    queue_line(10, 40, 20, 10);
    queue_line(40, 10, 10, 20);
    queue_line(40, 10, 30, 40);
    queue_line(0, 0, 63, 1);
    queue_line(0, 0, 1, 63);
    queue_line(7, 7, 8, 8);
    queue_line(7, 7, 8, 7);
    queue_line(20, 20, 31, 30);
    queue_line(20, 20, 30, 31);

    // Random lines: half unrestricted, some short, some axis-aligned or zero length.
    repeat (NUM_RANDOM) begin
      sel = $urandom_range(9);
      xs = $urandom_range(63);
      ys = $urandom_range(63);
      if (sel <= 4) begin
        queue_line(xs, ys, $urandom_range(63), $urandom_range(63));
      end else if (sel <= 7) begin
        queue_line(xs, ys, near_coord(xs), near_coord(ys));
      end else if (sel == 8) begin
        if ($urandom_range(1)) queue_line(xs, ys, $urandom_range(63), ys);
        else queue_line(xs, ys, xs, $urandom_range(63));
      end else begin
        queue_line(xs, ys, xs, ys);
      end
    end
    total_lines = line_q.size();

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (line_q.size() == 0 && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
